// ===== rtl/epa_pkg.sv =====
// Package for the Ed25519 affine point adder: field constants, widths, the
// cell link type and modular helpers. No dependencies.
`default_nettype none
package epa_pkg;
  localparam int LIMB_BITS = 64;
  localparam int NUM_LIMBS = 4;
  localparam int FE_BITS   = 256;
  localparam int DIGIT     = 16;               // bits per cell
  localparam int NCELL     = FE_BITS / DIGIT;  // cells in the chain
  localparam int CIN_W     = 8;                // width of a cell's carry-in

  localparam logic [255:0] P256  =
    256'h7fffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffed;
  localparam logic [255:0] PM2   = P256 - 256'd2;
  localparam logic [255:0] CURVE_D =
    256'h52036cee2b6ffe738cc740797779e89800700a4d4141d8ab75eb4dca135978a3;

  // Cell message handed up the chain each cycle while the chain is enabled.
  typedef struct packed {
    logic [DIGIT-1:0] acc;   // held digit of the accumulator
    logic [1:0]       cy;    // carry toward the upper neighbor, at most 2
  } cell_link_t;

  // Modular helpers, used by the sequencer and the multiplier on registered operands.
  function automatic logic [255:0] fe_fold(input logic [256:0] v);
    logic [256:0] t;
    t = {2'b0, v[254:0]} + (v[256:255] * 257'd19);
    t = {2'b0, t[254:0]} + (t[256:255] * 257'd19);
    if (t[255:0] >= P256) t = t - {1'b0, P256};
    return t[255:0];
  endfunction

  function automatic logic [255:0] fe_add(input logic [255:0] a, input logic [255:0] b);
    return fe_fold({1'b0, a} + {1'b0, b});
  endfunction

  // Both operands are canonical, so a + p - b stays below 2p.
  function automatic logic [255:0] fe_sub(input logic [255:0] a, input logic [255:0] b);
    return fe_fold({1'b0, a} + {1'b0, P256} - {1'b0, b});
  endfunction
endpackage
`default_nettype wire

// ===== rtl/epa_cell.sv =====
// One 16-bit cell of the carry-save multiplier chain.
// Depends on epa_pkg.
`default_nettype none
module epa_cell import epa_pkg::*; (
  input  wire logic             clk,
  input  wire logic             clr,
  input  wire logic             en,
  input  wire logic             abit,
  input  wire logic [DIGIT-1:0] bdig,
  input  wire logic [CIN_W-1:0] cin,
  output cell_link_t            link
);
  logic [DIGIT+1:0] sum;
  // Double the held digit, add the lower neighbor's top bit and carry, add a*b.
  always_comb begin
    sum = {2'b0, link.acc[DIGIT-2:0], 1'b0} + {{(DIGIT+2-CIN_W){1'b0}}, cin}
        + (abit ? {2'b0, bdig} : '0);
  end
  always_ff @(posedge clk) begin
    if (clr) begin
      link.acc <= '0;
      link.cy  <= '0;
    end else if (en) begin
      link.acc <= sum[DIGIT-1:0];
      link.cy  <= sum[DIGIT+1:DIGIT];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/epa_mul.sv =====
// Field multiplier mod 2^255-19 built as a chain of 16-bit cells, one
// multiplier bit per step; carries move one cell per cycle, the overflow
// folds into cell 0 as 38. Depends on epa_pkg and epa_cell.
`default_nettype none
module epa_mul import epa_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [255:0] a,
  input  wire logic [255:0] b,
  output logic              done,
  output logic [255:0]      prod
);
  localparam logic [1:0] F_IDLE = 2'd0, F_SUM = 2'd1, F_FOLD = 2'd2, F_OUT = 2'd3;

  logic [255:0]     ra, rb;
  logic [7:0]       cnt;
  logic             busy;
  logic [1:0]       fin;
  cell_link_t       links [NCELL];
  logic [255:0]     digits;
  logic [257:0]     carries;
  logic [257:0]     vsum;
  logic [256:0]     part;
  logic [2:0]       ovf;
  logic [CIN_W-1:0] cin0;

  // Weight 2^256 leaving the top cell re-enters cell 0 times 38.
  assign ovf  = {links[NCELL-1].cy, links[NCELL-1].acc[DIGIT-1]};
  assign cin0 = {{(CIN_W-3){1'b0}}, ovf} * 8'd38;

  genvar g;
  for (g = 0; g < NCELL; g++) begin : g_cell
    logic [CIN_W-1:0] cin;
    if (g == 0) begin : g_lo
      assign cin = cin0;
    end else begin : g_hi
      assign cin = {{(CIN_W-3){1'b0}}, links[g-1].cy, links[g-1].acc[DIGIT-1]};
    end
    epa_cell u_cell (
      .clk(clk), .clr(start), .en(busy), .abit(ra[255]),
      .bdig(rb[g*DIGIT +: DIGIT]), .cin(cin), .link(links[g])
    );
  end

  // Gather the cell digits and pending carries.
  always_comb begin
    digits  = '0;
    carries = '0;
    for (int i = 0; i < NCELL; i++) begin
      digits[i*DIGIT +: DIGIT]  = links[i].acc;
      carries[(i+1)*DIGIT +: 2] = links[i].cy;
    end
  end

  // Step the chain, then resolve carries (F_SUM), fold the overflow (F_FOLD) and reduce (F_OUT).
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; fin <= F_IDLE; done <= 1'b0; cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; cnt <= '0; ra <= a; rb <= b;
      end else if (busy) begin
        ra  <= {ra[254:0], 1'b0};
        cnt <= cnt + 8'd1;
        if (cnt == 8'd255) begin busy <= 1'b0; fin <= F_SUM; end
      end else begin
        case (fin)
          F_SUM: begin
            vsum <= {2'b0, digits} + carries; fin <= F_FOLD;
          end
          F_FOLD: begin
            part <= {2'b0, vsum[254:0]} + {249'b0, {5'b0, vsum[257:255]} * 8'd19};
            fin  <= F_OUT;
          end
          F_OUT: begin
            prod <= fe_fold(part); done <= 1'b1; fin <= F_IDLE;
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/ed25519_point_add_affine_top.sv =====
// Top level of the Ed25519 affine point adder: operand store, op sequencer,
// inversion and result streaming. Depends on epa_pkg and epa_mul.
//
// Usage: s_axis carries one input limb per transfer; tdata = limb_value,
// tuser = {limb_index, coord_select}, tlast = last_limb. A transfer with
// tlast stores its limb and starts the addition; s_axis_tready is low until
// all eight results have been transferred. m_axis returns x3 limbs 0..3 then
// y3 limbs 0..3; tdata = result_limb, tuser = {degenerate, result_index,
// result_coord}, tlast = last_result.
// Each field multiplication issues its operands, starts the multiplier, steps
// through the 256 multiplier bits, resolves carries and reduces, then takes
// the product. A run needs 519 multiplications; when Z3 is zero only seven
// are needed. Results then follow one per cycle while m_axis_tready is high.
// Only one run is in flight at a time. Reset clears control state only;
// stored limbs are undefined until written. A stalled m_axis holds the
// current result limb and its fields.
`default_nettype none
module ed25519_point_add_affine_top import epa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // [63:0] limb_value
  input  wire logic [3:0]  s_axis_tuser,  // [1:0] coord_select, [3:2] limb_index
  input  wire logic        s_axis_tlast,  // last_limb
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // [63:0] result_limb
  output logic [3:0]       m_axis_tuser,  // [0] result_coord, [2:1] result_index, [3] degenerate
  output logic             m_axis_tlast   // last_result
);
  localparam logic [3:0] S_LOAD = 4'd0, S_MUL = 4'd1, S_WAIT = 4'd2, S_OUT = 4'd3;

  logic [63:0]  ops [16];
  logic [3:0]   state;
  logic [5:0]   step;
  logic [8:0]   ebit;
  logic [255:0] x1, y1, x2, y2, ta, tb, ra, rb, rc, re, rf, rg, rh, rz, ri, rx, ry;
  logic [255:0] ma, mb, prod;
  logic         mstart, mdone, degen;
  logic [2:0]   ocnt;
  logic         s_fire, m_fire;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state == S_LOAD);

  epa_mul u_mul (.clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb),
                 .done(mdone), .prod(prod));

  // Store incoming limbs.
  always_ff @(posedge clk) begin
    if (s_fire) ops[{s_axis_tuser[1:0], s_axis_tuser[3:2]}] <= s_axis_tdata;
  end

  // Sequencer: step selects the multiplication; inversion loops on ebit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; mstart <= 1'b0; m_axis_tvalid <= 1'b0; ocnt <= '0; step <= '0;
    end else begin
      mstart <= 1'b0;
      case (state)
        S_LOAD: begin
          if (s_fire && s_axis_tlast) begin
            state <= S_MUL; step <= '0;
          end
        end
        S_MUL: begin
          if (step == 6'd0) begin
            x1 <= fe_fold({1'b0, ops[3], ops[2], ops[1], ops[0]});
            y1 <= fe_fold({1'b0, ops[7], ops[6], ops[5], ops[4]});
            x2 <= fe_fold({1'b0, ops[11], ops[10], ops[9], ops[8]});
            y2 <= fe_fold({1'b0, ops[15], ops[14], ops[13], ops[12]});
            step <= 6'd1;
          end else begin
            case (step)
              6'd1: begin ma <= x1; mb <= y1; end
              6'd2: begin ma <= x2; mb <= y2; end
              6'd3: begin ma <= fe_sub(y1, x1); mb <= fe_sub(y2, x2); end
              6'd4: begin ma <= fe_add(y1, x1); mb <= fe_add(y2, x2); end
              6'd5: begin ma <= ta; mb <= tb; end
              6'd6: begin ma <= rc; mb <= CURVE_D; end
              6'd7: begin
                rf <= fe_sub(256'd2, rc); rg <= fe_add(256'd2, rc);
                ma <= fe_sub(256'd2, rc); mb <= fe_add(256'd2, rc);
              end
              6'd8: begin ma <= ri; mb <= ri; end
              6'd9: begin ma <= ri; mb <= rz; end
              6'd10: begin ma <= re; mb <= rf; end
              6'd11: begin ma <= rx; mb <= ri; end
              6'd12: begin ma <= rg; mb <= rh; end
              6'd13: begin ma <= ry; mb <= ri; end
              default: begin ma <= '0; mb <= '0; end
            endcase
            mstart <= 1'b1; state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mdone) begin
            state <= S_MUL;
            case (step)
              6'd1: begin ta <= prod; step <= 6'd2; end
              6'd2: begin tb <= prod; step <= 6'd3; end
              6'd3: begin ra <= prod; step <= 6'd4; end
              6'd4: begin rb <= prod; step <= 6'd5; end
              6'd5: begin rc <= prod; step <= 6'd6; end
              6'd6: begin
                rc <= fe_add(prod, prod);
                re <= fe_sub(rb, ra);
                rh <= fe_add(rb, ra);
                step <= 6'd7;
              end
              6'd7: begin
                rz <= prod; ri <= 256'd1; ebit <= 9'd254;
                degen <= (prod == '0);
                if (prod == '0) begin
                  rx <= '0; ry <= '0; state <= S_OUT; ocnt <= '0; m_axis_tvalid <= 1'b1;
                end else step <= 6'd8;
              end
              6'd8: begin
                ri <= prod;
                if (PM2[ebit[7:0]]) step <= 6'd9;
                else if (ebit == 9'd0) step <= 6'd10;
                else ebit <= ebit - 9'd1;
              end
              6'd9: begin
                ri <= prod;
                if (ebit == 9'd0) step <= 6'd10;
                else begin ebit <= ebit - 9'd1; step <= 6'd8; end
              end
              6'd10: begin rx <= prod; step <= 6'd11; end
              6'd11: begin rx <= prod; step <= 6'd12; end
              6'd12: begin ry <= prod; step <= 6'd13; end
              6'd13: begin
                ry <= prod; state <= S_OUT; ocnt <= '0; m_axis_tvalid <= 1'b1;
              end
              default: state <= S_LOAD;
            endcase
          end
        end
        S_OUT: begin
          if (m_fire) begin
            ocnt <= ocnt + 3'd1;
            if (ocnt == 3'd7) begin m_axis_tvalid <= 1'b0; state <= S_LOAD; end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Present the current result limb.
  always_comb begin
    m_axis_tdata = ocnt[2] ? ry[ocnt[1:0]*64 +: 64] : rx[ocnt[1:0]*64 +: 64];
    m_axis_tuser = {degen, ocnt[1:0], ocnt[2]};
    m_axis_tlast = (ocnt == 3'd7);
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> !s_axis_tready) else $error("accept while busy");
  a_out_only_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (state == S_OUT)) else $error("result outside output phase");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (m_fire && m_axis_tlast) |=> (state == S_LOAD)) else $error("run did not end");
`endif
endmodule
`default_nettype wire

// ===== sim/ed25519_point_add_affine_top_tb.sv =====
// Testbench for ed25519_point_add_affine_top: loads operand limbs and checks
// the returned x3/y3 limbs against an in-bench modular arithmetic predictor.
// Depends on the RTL top level and epa_pkg (through the DUT only).
`default_nettype none
module ed25519_point_add_affine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 20_000_000;
  localparam logic [511:0] FIELD_P =
    512'h7fffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffed;
  localparam logic [255:0] FIELD_PM2 = FIELD_P[255:0] - 256'd2;
  localparam logic [255:0] EDW_D =
    256'h52036cee2b6ffe738cc740797779e89800700a4d4141d8ab75eb4dca135978a3;

  typedef logic [255:0] felem_t;

  typedef struct {
    logic [63:0] limb;
    logic [1:0]  coord;
    logic [1:0]  idx;
    logic        last;
    logic        hold;   // wait for all results before presenting
  } limb_load_t;

  typedef struct {
    logic [63:0] limb;
    logic        coord;
    logic [1:0]  idx;
    logic        degen;
    logic        last;
  } sum_limb_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [3:0] s_axis_tuser = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [3:0] m_axis_tuser;
  logic m_axis_tlast;

  limb_load_t load_q[$];
  sum_limb_t  sum_q[$];
  logic [63:0] limb_mirror[16];
  int loads_total = 0;
  int loads_done = 0;
  int offer_mark = 0;
  int errors = 0;
  int cycles = 0;

  ed25519_point_add_affine_top dut (.*);

  always #5 clk = ~clk;

  // Field arithmetic on canonical elements
  function automatic felem_t fmul(felem_t a, felem_t b);
    logic [511:0] prod;
    prod = {256'b0, a} * {256'b0, b};
    return felem_t'(prod % FIELD_P);
  endfunction

  function automatic felem_t fadd(felem_t a, felem_t b);
    logic [511:0] s;
    s = {256'b0, a} + {256'b0, b};
    return felem_t'(s % FIELD_P);
  endfunction

  function automatic felem_t fsub(felem_t a, felem_t b);
    logic [511:0] s;
    s = {256'b0, a} + FIELD_P - {256'b0, b};
    return felem_t'(s % FIELD_P);
  endfunction

  function automatic felem_t finv(felem_t z);
    felem_t r;
    r = 256'd1;
    for (int b = 254; b >= 0; b--) begin
      r = fmul(r, r);
      if (FIELD_PM2[b]) r = fmul(r, z);
    end
    return r;
  endfunction

  function automatic felem_t coord_value(int c);
    logic [511:0] v;
    v = {256'b0, limb_mirror[c*4+3], limb_mirror[c*4+2], limb_mirror[c*4+1],
         limb_mirror[c*4]};
    return felem_t'(v % FIELD_P);
  endfunction

  // Add the stored points and queue the eight expected result limbs
  task automatic predict_point_sum();
    felem_t x1, y1, x2, y2, c, e, f, g, h, a, bb, z3, zi, x3, y3;
    sum_limb_t r;
    logic degen;
    x1 = coord_value(0);
    y1 = coord_value(1);
    x2 = coord_value(2);
    y2 = coord_value(3);
    a  = fmul(fsub(y1, x1), fsub(y2, x2));
    bb = fmul(fadd(y1, x1), fadd(y2, x2));
    c  = fmul(fmul(fmul(x1, y1), fmul(x2, y2)), EDW_D);
    c  = fadd(c, c);
    e  = fsub(bb, a);
    f  = fsub(256'd2, c);
    g  = fadd(256'd2, c);
    h  = fadd(bb, a);
    z3 = fmul(f, g);
    degen = (z3 == '0);
    if (degen) begin
      x3 = '0;
      y3 = '0;
    end else begin
      zi = finv(z3);
      x3 = fmul(fmul(e, f), zi);
      y3 = fmul(fmul(g, h), zi);
    end
    for (int k = 0; k < 8; k++) begin
      r.limb  = (k < 4) ? x3[(k%4)*64 +: 64] : y3[(k%4)*64 +: 64];
      r.coord = (k >= 4);
      r.idx   = 2'(k % 4);
      r.degen = degen;
      r.last  = (k == 7);
      sum_q.push_back(r);
    end
  endtask

  // Queue a whole load of all sixteen limbs in shuffled order, run on the last
  task automatic queue_point_pair(felem_t x1, felem_t y1, felem_t x2, felem_t y2,
                                  bit hold);
    limb_load_t it;
    int order[16];
    int j, t;
    felem_t v;
    for (int i = 0; i < 16; i++) order[i] = i;
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(i, 0);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < 16; i++) begin
      case (order[i] / 4)
        0: v = x1;
        1: v = y1;
        2: v = x2;
        default: v = y2;
      endcase
      it.limb  = v[(order[i]%4)*64 +: 64];
      it.coord = 2'(order[i] / 4);
      it.idx   = 2'(order[i] % 4);
      it.last  = (i == 15);
      it.hold  = hold && (i == 0);
      load_q.push_back(it);
    end
  endtask

  function automatic felem_t rand_felem();
    felem_t v;
    for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
    case ($urandom_range(7, 0))
      0: v = '1;
      1: v = '0;
      2: v[63:0] = 64'hffff_ffff_ffff_ffff;
      default: ;
    endcase
    return v;
  endfunction

  // Stimulus
  initial begin
    limb_load_t it;
    felem_t inv_d;
    inv_d = finv(EDW_D);
    // all-zero coordinates
    queue_point_pair('0, '0, '0, '0, 1'b0);
    // all-ones limbs, above the modulus
    queue_point_pair('1, '1, '1, '1, 1'b0);
    // d*x1*y1*x2*y2 = 1 makes Z3 zero
    queue_point_pair(256'd1, 256'd1, 256'd1, inv_d, 1'b1);
    // stale limbs: rewrite only the low limb of x2, the rest kept
    it.limb = 64'hffff_ffff_ffff_ffed; it.coord = 2'd2; it.idx = 2'd0;
    it.last = 1'b1; it.hold = 1'b0;
    load_q.push_back(it);
    // random pairs; after one of them a load rewrites only three limbs
    for (int r = 0; r < 5; r++) begin
      queue_point_pair(rand_felem(), rand_felem(), rand_felem(), rand_felem(),
                       r == 2);
      if (r == 3) begin
        for (int k = 0; k < 3; k++) begin
          it.limb  = {$urandom, $urandom};
          it.coord = 2'($urandom_range(3, 0));
          it.idx   = 2'($urandom_range(3, 0));
          it.last  = (k == 2);
          it.hold  = 1'b0;
          load_q.push_back(it);
        end
      end
    end
    loads_total = load_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (load_q.size() == 0);
    wait (sum_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Idle rates per phase: sender 16/rx 51, then swapped, then none
  function automatic bit send_idle();
    if (loads_done < loads_total / 3) return $urandom_range(99, 0) < 16;
    if (loads_done < 2 * loads_total / 3) return $urandom_range(99, 0) < 51;
    return 1'b0;
  endfunction

  function automatic bit recv_idle();
    if (loads_done < loads_total / 3) return $urandom_range(99, 0) < 51;
    if (loads_done < 2 * loads_total / 3) return $urandom_range(99, 0) < 16;
    return 1'b0;
  endfunction

  // Accept input transfers: update the limb mirror and predict on tlast
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      limb_mirror[{s_axis_tuser[1:0], s_axis_tuser[3:2]}] = s_axis_tdata;
      if (s_axis_tlast) predict_point_sum();
      void'(load_q.pop_front());
      loads_done++;
    end
  end

  // Drive the slave side and m_axis_tready at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      // hold an offered item until it has been taken
      if (!s_axis_tvalid || loads_done != offer_mark) begin
        if (load_q.size() != 0 && !send_idle()
            && !(load_q[0].hold && sum_q.size() != 0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= load_q[0].limb;
          s_axis_tuser  <= {load_q[0].idx, load_q[0].coord};
          s_axis_tlast  <= load_q[0].last;
          offer_mark    <= loads_done;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !recv_idle();
    end
  end

  // Check result transfers against the oldest expectation
  always @(posedge clk) begin
    sum_limb_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (sum_q.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tuser=%h tlast=%b", $time,
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        exp_r = sum_q.pop_front();
        if (m_axis_tdata !== exp_r.limb) begin
          $display("%0t: result_limb expected %h actual %h", $time, exp_r.limb,
                   m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser[0] !== exp_r.coord) begin
          $display("%0t: result_coord expected %b actual %b", $time, exp_r.coord,
                   m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[2:1] !== exp_r.idx) begin
          $display("%0t: result_index expected %0d actual %0d", $time, exp_r.idx,
                   m_axis_tuser[2:1]);
          errors++;
        end
        if (m_axis_tuser[3] !== exp_r.degen) begin
          $display("%0t: degenerate expected %b actual %b", $time, exp_r.degen,
                   m_axis_tuser[3]);
          errors++;
        end
        if (m_axis_tlast !== exp_r.last) begin
          $display("%0t: last_result expected %b actual %b", $time, exp_r.last,
                   m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end
endmodule
`default_nettype wire
